FILE: sv/i2a_pkg.sv
// Shared types, constants and helpers for the integer to ASCII converter.
// No dependencies; every other file but i2a_queue imports this package.

package i2a_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic KIND_DEC = 1'b0;
	localparam logic KIND_HEX = 1'b1;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_F    = 8'h46;
	localparam logic [7:0] CHAR_X    = 8'h78;

	typedef struct packed {
		logic        kind;
		logic [63:0] value;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_beat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ZERO,
		B_PFX0,
		B_PFXX,
		B_DIG
	} back_state_t;

	// Decimal digits needed for the largest value of w bits; this also covers
	// the hex digit count, so it sizes the digit buffer for both kinds.
	function automatic int dec_digits(int w);
		return (w * 301) / 1000 + 1;
	endfunction

	function automatic logic [7:0] digit_char(logic [3:0] d);
		logic [7:0] wide;
		wide = {4'b0000, d};
		if (d < 4'd10)
			return CHAR_ZERO + wide;
		return CHAR_A + (wide - 8'd10);
	endfunction

endpackage

FILE: sv/i2a_front.sv
// Front end: accepts a value, turns it into a row of decimal or hex digits
// and counts the significant ones. Depends on i2a_pkg.

module i2a_front #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF,
	localparam int ND = i2a_pkg::dec_digits(VALUE_WIDTH),
	localparam int CW = $clog2(ND + 1),
	localparam int EW = 1 + CW + 4 * ND
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  i2a_pkg::in_beat_t   item,
	output logic                push,
	output logic [EW-1:0]       entry,
	input  logic                full
);
	import i2a_pkg::*;

	localparam int NW = $clog2(VALUE_WIDTH);

	front_state_t            state_q, state_d;
	logic                    kind_q;
	logic [VALUE_WIDTH-1:0]  shift_q;
	logic [4*ND-1:0]         bcd_q;
	logic [4*ND-1:0]         adj;
	logic [NW-1:0]           cnt_q;
	logic [CW-1:0]           ndig;
	logic                    take;

	assign take = item_valid && !item_stall;

	// Shift-and-add-3: every BCD digit of five or more is corrected before
	// the next binary bit is shifted in.
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// Position of the most significant non-zero digit; zero for a zero value.
	always_comb begin
		ndig = '0;
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0)
				ndig = CW'(i + 1);
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		push       = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				item_stall = 1'b0;
				if (item_valid)
					state_d = (item.kind == KIND_HEX) ? F_PUSH : F_CONV;
			end
			F_CONV: begin
				if (cnt_q == '0)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				push = 1'b1;
				if (!full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= item.kind;
			shift_q <= item.value[VALUE_WIDTH-1:0];
			cnt_q   <= NW'(VALUE_WIDTH - 1);
			if (item.kind == KIND_HEX)
				bcd_q <= {{(4*ND-VALUE_WIDTH){1'b0}}, item.value[VALUE_WIDTH-1:0]};
			else
				bcd_q <= '0;
		end else if (state_q == F_CONV) begin
			bcd_q   <= {adj[4*ND-2:0], shift_q[VALUE_WIDTH-1]};
			shift_q <= {shift_q[VALUE_WIDTH-2:0], 1'b0};
			cnt_q   <= cnt_q - NW'(1);
		end
	end

	assign entry = {kind_q, ndig, bcd_q};

endmodule

FILE: sv/i2a_queue.sv
// Short register queue between the digit front end and the character back end.
// Depends on nothing but its parameters.

module i2a_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             avail
);
	localparam int PW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr, do_rd;

	assign full  = (count_q == CNTW'(DEPTH));
	assign avail = (count_q != '0);
	assign do_wr = push && !full;
	assign do_rd = pop && avail;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNTW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

FILE: sv/i2a_back.sv
// Back end: takes a row of digits from the queue and sends it out one ASCII
// character per beat, with the hex prefix and the last flag. Depends on i2a_pkg.

module i2a_back #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF,
	localparam int ND = i2a_pkg::dec_digits(VALUE_WIDTH),
	localparam int CW = $clog2(ND + 1),
	localparam int EW = 1 + CW + 4 * ND
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [EW-1:0]      entry,
	input  logic               avail,
	output logic               pop,
	output logic               text_valid,
	input  logic               text_stall,
	output i2a_pkg::out_beat_t text
);
	import i2a_pkg::*;

	localparam int PW = $clog2(ND);

	back_state_t           state_q, state_d;
	logic [ND-1:0][3:0]    digits_q;
	logic [PW-1:0]         pos_q, pos_d;
	logic                  valid_q;
	out_beat_t             text_q, beat;
	logic                  out_free, emit;
	logic                  e_kind;
	logic [CW-1:0]         e_ndig;

	assign e_kind   = entry[EW-1];
	assign e_ndig   = entry[4*ND +: CW];
	assign out_free = !valid_q || !text_stall;

	always_comb begin
		state_d        = state_q;
		pop            = 1'b0;
		emit           = 1'b0;
		pos_d          = pos_q;
		beat.character = CHAR_ZERO;
		beat.last      = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (avail) begin
					pop   = 1'b1;
					pos_d = PW'(e_ndig - CW'(1));
					if (e_ndig == '0)
						state_d = B_ZERO;
					else if (e_kind == KIND_HEX)
						state_d = B_PFX0;
					else
						state_d = B_DIG;
				end
			end
			B_ZERO: begin
				beat.last = 1'b1;
				if (out_free) begin
					emit    = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_PFX0: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = B_PFXX;
				end
			end
			B_PFXX: begin
				beat.character = CHAR_X;
				if (out_free) begin
					emit    = 1'b1;
					state_d = B_DIG;
				end
			end
			B_DIG: begin
				beat.character = digit_char(digits_q[pos_q]);
				beat.last      = (pos_q == '0);
				if (out_free) begin
					emit = 1'b1;
					if (pos_q == '0)
						state_d = B_IDLE;
					else
						pos_d = pos_q - PW'(1);
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_free)
				valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (pop)
			digits_q <= entry[4*ND-1:0];
		if (emit)
			text_q <= beat;
	end

	assign text_valid = valid_q;
	assign text       = text_q;

endmodule

FILE: sv/integer_to_ascii_digits.sv
// Top level of the integer to ASCII converter: front end, queue and back end.
// Depends on i2a_pkg, i2a_front, i2a_queue and i2a_back.
//
// The item channel (item_valid, item_stall, item) takes one beat per value:
// item.kind selects decimal or hex, item.value holds the number, of which the
// low VALUE_WIDTH bits are used. The text channel (text_valid, text_stall,
// text) gives one beat per character, most significant digit first, leading
// zeros suppressed, hex digits in upper case after "0x". text.last marks the
// final character of a value; a zero value gives a single '0'.
// A decimal value occupies the front end for one shift-and-add-3 step per input
// bit; a hex value is pushed to the queue without conversion. The back end
// takes a row from the queue in its idle state and then gives one character
// per cycle while the receiver does not stall. The first character of a value
// is registered in the output register once the back end has taken its row.
// A queue of QUEUE_DEPTH rows lets the front end convert the next value while
// characters are still going out. When the receiver stalls, the current
// character waits in the output register, the back end holds, the queue fills
// and item_stall rises. Reset empties the queue and drops text_valid.

module integer_to_ascii_digits #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = i2a_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  i2a_pkg::in_beat_t  item,
	output logic               text_valid,
	input  logic               text_stall,
	output i2a_pkg::out_beat_t text
);
	import i2a_pkg::*;

	localparam int ND = dec_digits(VALUE_WIDTH);
	localparam int CW = $clog2(ND + 1);
	localparam int EW = 1 + CW + 4 * ND;

	logic          push, full, pop, avail;
	logic [EW-1:0] wr_entry, rd_entry;

	i2a_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.entry      (wr_entry),
		.full       (full)
	);

	i2a_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.full   (full),
		.pop    (pop),
		.rdata  (rd_entry),
		.avail  (avail)
	);

	i2a_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry      (rd_entry),
		.avail      (avail),
		.pop        (pop),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

endmodule

FILE: sv/i2a_checker.sv
// Port-level checks for integer_to_ascii_digits, attached by the bind below.
// Depends on i2a_pkg.

module i2a_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input i2a_pkg::in_beat_t  item,
	input logic               text_valid,
	input logic               text_stall,
	input i2a_pkg::out_beat_t text
);
	import i2a_pkg::*;

	// The front end is busy in the cycle after it takes a value.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item channel ready straight after a beat was taken");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> text_valid)
		else $error("text beat withdrawn while stalled");

	a_text_stable: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> $stable(text))
		else $error("text beat changed while stalled");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |->
			(text.character >= CHAR_ZERO && text.character <= CHAR_NINE) ||
			(text.character >= CHAR_A && text.character <= CHAR_F) ||
			(text.character == CHAR_X))
		else $error("character outside the digit set");

	// The prefix can never end a run.
	a_prefix_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text.character == CHAR_X |-> !text.last)
		else $error("prefix flagged as last character");

endmodule

bind integer_to_ascii_digits i2a_checker u_i2a_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.item       (item),
	.text_valid (text_valid),
	.text_stall (text_stall),
	.text       (text)
);

FILE: bench/tb_top.sv
// Self-checking bench for integer_to_ascii_digits: random and directed values in
// both kinds, with the expected characters computed alongside. Needs i2a_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

	import i2a_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam logic [63:0] VALUE_MASK = (VW >= 64) ? {64{1'b1}} : ((64'd1 << VW) - 64'd1);

	typedef struct {
		in_beat_t    beat;
		int unsigned gap;
		bit          drain;
	} pending_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	in_beat_t   item = '0;
	logic       text_valid;
	logic       text_stall = 1'b0;
	out_beat_t  text;

	pending_t    pending_items[$];
	out_beat_t   expected_chars[$];
	int unsigned fail_count = 0;
	bit          item_taken = 1'b0;
	bit          text_taken = 1'b0;
	bit          gap_armed = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	bit          tx_calm = 1'b0;
	bit          rx_busy = 1'b1;

	integer_to_ascii_digits u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text      (text)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Appends the characters that one accepted value should produce.
	task automatic queue_text_for(input in_beat_t b);
		logic [63:0] v;
		logic [63:0] base;
		logic [3:0]  digits[20];
		int          n;
		out_beat_t   c;
		v = b.value & VALUE_MASK;
		base = (b.kind == KIND_HEX) ? 64'd16 : 64'd10;
		n = 0;
		if (v == 64'd0) begin
			c.character = CHAR_ZERO;
			c.last = 1'b1;
			expected_chars.push_back(c);
		end else begin
			while (v != 64'd0 && n < 20) begin
				digits[n] = 4'(v % base);
				v = v / base;
				n++;
			end
			if (b.kind == KIND_HEX) begin
				c.last = 1'b0;
				c.character = CHAR_ZERO;
				expected_chars.push_back(c);
				c.character = CHAR_X;
				expected_chars.push_back(c);
			end
			for (int i = n - 1; i >= 0; i--) begin
				if (digits[i] < 4'd10)
					c.character = CHAR_ZERO + {4'b0000, digits[i]};
				else
					c.character = CHAR_A + ({4'b0000, digits[i]} - 8'd10);
				c.last = (i == 0);
				expected_chars.push_back(c);
			end
		end
	endtask

	task automatic add_item(input logic k, input logic [63:0] v, input bit drain);
		pending_t p;
		p.beat.kind = k;
		p.beat.value = v;
		p.gap = tx_calm ? 0 : $urandom_range(0, 15);
		p.drain = drain;
		pending_items.push_back(p);
	endtask

	task automatic add_random_item(input bit drain);
		logic [63:0] v;
		int unsigned pick;
		int unsigned w;
		v = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			v = 64'($urandom_range(0, 20));
		end else if (pick < 85) begin
			w = $urandom_range(1, 64);
			v = v >> (64 - w);
		end
		add_item(1'($urandom_range(0, 1)), v, drain);
	endtask

	task automatic wait_for_drain();
		while (pending_items.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// Sender: a beat is dropped on the falling edge after it was taken, and the
	// next one, if its gap is zero and it need not wait for a drain, goes out in the same assignment.
	always @(negedge clk) begin : drive_items
		logic nv;
		if (arst_n) begin
			nv = item_valid;
			if (item_valid && item_taken) begin
				nv = 1'b0;
				item_taken = 1'b0;
			end
			if (!nv && pending_items.size() != 0) begin
				if (!gap_armed) begin
					gap_left = pending_items[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else if (!pending_items[0].drain ||
						(expected_chars.size() == 0 && !text_valid)) begin
					item <= pending_items[0].beat;
					pending_items.pop_front();
					nv = 1'b1;
					gap_armed = 1'b0;
				end
			end
			item_valid <= nv;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (text_taken) begin
				text_taken = 1'b0;
				stall_left = rx_busy ? $urandom_range(0, 15) : 0;
			end
			if (stall_left != 0) begin
				text_stall <= 1'b1;
				stall_left--;
			end else begin
				text_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_beats
		out_beat_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				queue_text_for(item);
				item_taken = 1'b1;
			end
			if (text_valid && !text_stall) begin
				text_taken = 1'b1;
				if (expected_chars.size() == 0) begin
					$error("character: none expected, got %h (last %b)", text.character,
						text.last);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (text.character !== want.character) begin
						$error("character: expected %h, got %h", want.character,
							text.character);
						fail_count++;
					end
					if (text.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, text.last);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		wait (arst_n);
		// Directed values: zero in both kinds, digit boundaries and the extremes.
		add_item(KIND_DEC, 64'd0, 1'b0);
		add_item(KIND_HEX, 64'd0, 1'b0);
		add_item(KIND_DEC, 64'd1, 1'b0);
		add_item(KIND_HEX, 64'd1, 1'b0);
		add_item(KIND_DEC, 64'd9, 1'b0);
		add_item(KIND_DEC, 64'd10, 1'b0);
		add_item(KIND_HEX, 64'd9, 1'b0);
		add_item(KIND_HEX, 64'd10, 1'b0);
		add_item(KIND_HEX, 64'd15, 1'b0);
		add_item(KIND_HEX, 64'd16, 1'b0);
		add_item(KIND_HEX, 64'd255, 1'b0);
		add_item(KIND_DEC, 64'd99, 1'b0);
		add_item(KIND_DEC, 64'd100, 1'b0);
		add_item(KIND_DEC, 64'd9999999999999999999, 1'b0);
		add_item(KIND_DEC, 64'd10000000000000000000, 1'b0);
		add_item(KIND_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		add_item(KIND_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		add_item(KIND_HEX, 64'h0123_4567_89AB_CDEF, 1'b0);
		add_item(KIND_HEX, 64'hFEDC_BA98_7654_3210, 1'b0);
		add_item(KIND_DEC, 64'h8000_0000_0000_0000, 1'b0);
		add_item(KIND_HEX, 64'h8000_0000_0000_0000, 1'b0);
		add_item(KIND_DEC, 64'h5555_5555_5555_5555, 1'b0);
		add_item(KIND_HEX, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		add_item(KIND_DEC, 64'd1234567890, 1'b0);
		wait_for_drain();

		// No idling on either side.
		tx_calm = 1'b1;
		rx_busy = 1'b0;
		repeat (60) add_random_item(1'b0);
		wait_for_drain();

		// Both sides idle at random; now and then the sender waits for the text
		// of everything already taken before it offers the next beat.
		tx_calm = 1'b0;
		rx_busy = 1'b1;
		for (int i = 0; i < 150; i++)
			add_random_item($urandom_range(0, 19) == 0);
		wait_for_drain();

		// Sender flat out against a stalling receiver, so the queue backs up.
		tx_calm = 1'b1;
		rx_busy = 1'b1;
		repeat (50) add_random_item(1'b0);
		wait_for_drain();

		tx_calm = 1'b0;
		rx_busy = 1'b0;
		repeat (50) add_random_item(1'b0);
		wait_for_drain();

		repeat (100) @(posedge clk);
		if (fail_count == 0 && expected_chars.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
